>>> src/dtd_pkg.sv
// shared types and constants for the double-talk detector
// no dependencies; used by every module of the block

package dtd_pkg;

    localparam int unsigned PWR_W   = 32;   // unsigned q8.24 powers and ratios
    localparam int unsigned LIK_W   = 16;   // unsigned q1.15 likelihoods
    localparam int unsigned WGT_W   = 16;   // q0.16 smoothing weights
    localparam int unsigned ACC_W   = 32;   // weighted sum, at most 2^31
    localparam int unsigned FRM_W   = 16;
    localparam int unsigned ACT_W   = 2;
    localparam int unsigned CFG_AW  = 1;
    localparam int unsigned DIV_STEPS = PWR_W;
    localparam int unsigned DIV_CW  = $clog2(DIV_STEPS);

    localparam int unsigned S_TDATA_W = 184;
    localparam int unsigned M_TDATA_W = 64;

    localparam logic [FRM_W-1:0] FRAME_GATE = 16'd50;
    localparam logic [PWR_W-1:0] ONE_Q24    = 32'h0100_0000;
    localparam logic [LIK_W-1:0] ONE_Q15    = 16'h8000;
    localparam logic [PWR_W-1:0] FAR_MIN    = 32'd1677;
    localparam logic [PWR_W-1:0] ERL_FLOOR  = 32'd167772;
    localparam logic [PWR_W-1:0] PWR_ONES   = 32'hFFFF_FFFF;

    localparam logic [WGT_W-1:0] W_07  = 16'd45875;
    localparam logic [WGT_W-1:0] W_03  = 16'd19661;
    localparam logic [WGT_W-1:0] W_09  = 16'd58982;
    localparam logic [WGT_W-1:0] W_01  = 16'd6554;
    localparam logic [WGT_W-1:0] W_095 = 16'd62259;
    localparam logic [WGT_W-1:0] W_0   = 16'd0;

    localparam logic [CFG_AW-1:0] REG_OFFSET = 1'b0;
    localparam logic [CFG_AW-1:0] REG_SCALE  = 1'b1;

    typedef enum logic [ACT_W-1:0] {
        ACT_SHADOW = 2'd0,
        ACT_ENERGY = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> src/dtd_div.sv
// shared restoring divider, one quotient bit per cycle
// divides {hi, lo} by den where hi < den; depends on dtd_pkg

module dtd_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [dtd_pkg::PWR_W-1:0]  i_hi,
    input  logic [dtd_pkg::PWR_W-1:0]  i_lo,
    input  logic [dtd_pkg::PWR_W-1:0]  i_den,
    output dtd_pkg::t_div_stat         o_stat,
    output logic [dtd_pkg::PWR_W-1:0]  o_quo
);
    import dtd_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [PWR_W-1:0]  r_rem;
    logic [PWR_W-1:0]  r_lo;
    logic [PWR_W-1:0]  r_den;
    logic [PWR_W-1:0]  r_quo;

    logic [PWR_W:0]    trial;
    logic              ge;
    logic [PWR_W:0]    diff;

    assign trial = {r_rem, r_lo[PWR_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_hi;
            r_lo  <= i_lo;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            // remainder stays below the divisor, so its top bit drops out
            r_rem <= ge ? diff[PWR_W-1:0] : trial[PWR_W-1:0];
            r_lo  <= {r_lo[PWR_W-2:0], 1'b0};
            r_quo <= {r_quo[PWR_W-2:0], ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy))
        else $error("divider done without a finished run");

endmodule

>>> src/dtd_mac.sv
// multiply-accumulate unit for the likelihood smoothing
// one 16x16 product per cycle while enabled into a registered sum; depends on dtd_pkg

module dtd_mac (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic                       i_clr,
    input  logic [dtd_pkg::WGT_W-1:0]  i_wgt,
    input  logic [dtd_pkg::LIK_W-1:0]  i_val,
    output logic [dtd_pkg::ACC_W-1:0]  o_acc
);
    import dtd_pkg::*;

    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] prod;

    assign prod = ACC_W'(i_wgt) * ACC_W'(i_val);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= (i_clr ? '0 : r_acc) + prod;
        end
    end

    assign o_acc = r_acc;

endmodule

>>> src/double_talk_detector_core.sv
// double-talk detector: clear or unused actions go from dispatch to done, a shadow
// decay through both multiply steps and write-back, a shadow or energy update through
// up to two shared-divider runs before them; one item at a time, the next item can be
// taken the cycle after the output register takes the result, past any output stall
// synchronous active-low reset: likelihoods to 0, ratio to 1.0, registers to 1.0
// depends on dtd_pkg, dtd_div and dtd_mac

module double_talk_detector_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tdata: shadow_frames[15:0], excite_flag[16], main_error_power[48:17],
    // shadow_error_power[80:49], talk_flag[81], far_power[113:82],
    // mic_power[145:114], echo_return_loss[177:146], zero fill to 184
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [dtd_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic [dtd_pkg::ACT_W-1:0]      i_s_tuser,   // action
    // tdata: energy_likelihood[15:0], shadow_likelihood[31:16], advantage_ratio[63:32]
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [dtd_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input  logic                           i_cfg_we,
    input  logic [dtd_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  logic [dtd_pkg::PWR_W-1:0]      i_cfg_wdata
);
    import dtd_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DISP = 9'b000000010,
        S_DIV1 = 9'b000000100,
        S_MID  = 9'b000001000,
        S_DIV2 = 9'b000010000,
        S_MUL1 = 9'b000100000,
        S_MUL2 = 9'b001000000,
        S_WB   = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [PWR_W-1:0] r_offset, r_scale;
    logic [LIK_W-1:0] r_energy_dt, r_shadow_dt;
    logic [PWR_W-1:0] r_ratio;

    t_action          r_action;
    logic [FRM_W-1:0] r_frames;
    logic             r_excited, r_active;
    logic [PWR_W-1:0] r_main, r_shadow_p, r_far, r_mic, r_erl;

    logic [PWR_W-1:0] r_q1;
    logic [LIK_W-1:0] r_new;
    logic             r_gated;
    logic             r_o_valid;
    logic [M_TDATA_W-1:0] r_o_data;

    logic             in_acc, out_load;
    logic             is_shadow;
    logic             gated, energy_ok;
    logic [PWR_W-1:0] erl_c, shd_den, ex, diff;
    logic [PWR_W-1:0] div_hi, div_lo, div_den;
    logic             div_sat, div_start;
    t_div_stat        div_stat;
    logic [PWR_W-1:0] div_quo;
    logic [WGT_W-1:0] w_old, w_new, mac_wgt;
    logic [LIK_W-1:0] old_val, mac_val;
    logic [ACC_W-1:0] mac_acc;
    logic [LIK_W-1:0] blend_res;

    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_load   = (r_state == S_DONE) && (!r_o_valid || i_m_tready);

    assign is_shadow = (r_action == ACT_SHADOW);
    assign gated     = (r_frames >= FRAME_GATE) && r_excited;
    assign energy_ok = r_active && (r_far > FAR_MIN) && (r_mic != '0);
    assign erl_c     = (r_erl < ERL_FLOOR) ? ERL_FLOOR : r_erl;
    assign shd_den   = (r_shadow_p == '0) ? PWR_W'(1) : r_shadow_p;
    assign ex        = r_q1 - r_offset;
    assign diff      = r_mic - r_q1;

    // dividend split into hi and lo words; hi >= den means the quotient overflows
    always_comb begin
        if (r_state == S_DISP) begin
            if (is_shadow) begin
                div_hi  = {8'd0, r_main[31:8]};
                div_lo  = {r_main[7:0], 24'd0};
                div_den = shd_den;
            end else begin
                div_hi  = {7'd0, r_far[31:7]};
                div_lo  = {r_far[6:0], 25'd0};
                div_den = erl_c;
            end
        end else begin
            if (is_shadow) begin
                div_hi  = {17'd0, ex[31:17]};
                div_lo  = {ex[16:0], 15'd0};
                div_den = r_scale;
            end else begin
                div_hi  = {17'd0, diff[31:17]};
                div_lo  = {diff[16:0], 15'd0};
                div_den = r_mic;
            end
        end
    end

    assign div_sat = div_hi >= div_den;

    always_comb begin
        div_start = 1'b0;
        if (r_state == S_DISP) begin
            div_start = !div_sat && ((is_shadow && gated) ||
                                     (r_action == ACT_ENERGY && energy_ok));
        end else if (r_state == S_MID) begin
            div_start = is_shadow ? ((r_q1 > r_offset) && !div_sat) : (r_mic > r_q1);
        end
    end

    always_comb begin
        if (is_shadow) begin
            old_val = r_shadow_dt;
            w_old   = r_gated ? W_07 : W_095;
            w_new   = r_gated ? W_03 : W_0;
        end else begin
            old_val = r_energy_dt;
            // fast rise, slow decay
            w_old   = (r_new > r_energy_dt) ? W_03 : W_09;
            w_new   = (r_new > r_energy_dt) ? W_07 : W_01;
        end
    end

    assign mac_wgt   = (r_state == S_MUL1) ? w_old : w_new;
    assign mac_val   = (r_state == S_MUL1) ? old_val : r_new;
    assign blend_res = mac_acc[LIK_W+15:16];

    dtd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_hi    (div_hi),
        .i_lo    (div_lo),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    dtd_mac u_mac (
        .i_clk (i_clk),
        .i_en  ((r_state == S_MUL1) || (r_state == S_MUL2)),
        .i_clr (r_state == S_MUL1),
        .i_wgt (mac_wgt),
        .i_val (mac_val),
        .o_acc (mac_acc)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_DISP;
            S_DISP: begin
                unique case (r_action)
                    ACT_SHADOW: begin
                        if (!gated)          n_state = S_MUL1;
                        else if (div_start)  n_state = S_DIV1;
                        else                 n_state = S_MID;
                    end
                    ACT_ENERGY: n_state = div_start ? S_DIV1 : S_MID;
                    ACT_CLEAR:  n_state = S_DONE;
                    ACT_NONE:   n_state = S_DONE;
                    default:    n_state = S_DONE;
                endcase
            end
            S_DIV1: if (div_stat.done) n_state = S_MID;
            S_MID:  n_state = div_start ? S_DIV2 : S_MUL1;
            S_DIV2: if (div_stat.done) n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_WB;
            S_WB:   n_state = S_DONE;
            S_DONE: if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_o_valid   <= 1'b0;
            r_offset    <= ONE_Q24;
            r_scale     <= ONE_Q24;
            r_energy_dt <= '0;
            r_shadow_dt <= '0;
            r_ratio     <= ONE_Q24;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_OFFSET: r_offset <= i_cfg_wdata;
                    REG_SCALE:  r_scale  <= i_cfg_wdata;
                    default:    r_offset <= r_offset;
                endcase
            end
            if (r_state == S_DISP && r_action == ACT_CLEAR) begin
                r_energy_dt <= '0;
                r_shadow_dt <= '0;
                r_ratio     <= ONE_Q24;
            end
            if (r_state == S_MID && is_shadow) begin
                r_ratio <= r_q1;
            end
            if (r_state == S_WB) begin
                if (is_shadow) begin
                    r_shadow_dt <= blend_res;
                end else begin
                    r_energy_dt <= blend_res;
                end
            end
        end
    end

    // item payload and working values
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action   <= t_action'(i_s_tuser);
            r_frames   <= i_s_tdata[15:0];
            r_excited  <= i_s_tdata[16];
            r_main     <= i_s_tdata[48:17];
            r_shadow_p <= i_s_tdata[80:49];
            r_active   <= i_s_tdata[81];
            r_far      <= i_s_tdata[113:82];
            r_mic      <= i_s_tdata[145:114];
            r_erl      <= i_s_tdata[177:146];
        end
        if (r_state == S_DISP) begin
            r_gated <= gated;
            r_new   <= '0;
            // energy overflow or no energy estimate: all ones makes inst zero later
            r_q1    <= PWR_ONES;
        end
        if (r_state == S_DIV1 && div_stat.done) begin
            r_q1 <= div_quo;
        end
        if (r_state == S_MID) begin
            r_new <= (is_shadow && (r_q1 > r_offset) && div_sat) ? ONE_Q15 : '0;
        end
        if (r_state == S_DIV2 && div_stat.done) begin
            r_new <= (div_quo > PWR_W'(ONE_Q15)) ? ONE_Q15 : div_quo[LIK_W-1:0];
        end
        if (out_load) begin
            r_o_data <= {r_ratio, r_shadow_dt, r_energy_dt};
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

    a_energy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_energy_dt <= ONE_Q15)
        else $error("energy likelihood above one");

    a_shadow_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shadow_dt <= ONE_Q15)
        else $error("shadow likelihood above one");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV1 || r_state == S_DIV2))
        else $error("divider finished outside a wait state");

    a_ratio_on_shadow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ratio != $past(r_ratio)) |->
            ($past(r_state) == S_MID || $past(r_state) == S_DISP))
        else $error("advantage ratio changed outside an update");

endmodule

>>> dv/double_talk_detector_checker.sv
`timescale 1ns / 1ps
// result checker for double_talk_detector_core: follows config writes and accepted items,
// predicts each result and compares it field by field; depends on dtd_pkg

module double_talk_detector_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [dtd_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic [dtd_pkg::ACT_W-1:0]     i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [dtd_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  logic                          i_cfg_we,
    input  logic [dtd_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [dtd_pkg::PWR_W-1:0]     i_cfg_wdata,
    output int                            o_fail_count,
    output int                            o_pending
);
    import dtd_pkg::*;

    // same layout as the result tdata, highest field first
    typedef struct packed {
        logic [PWR_W-1:0] ratio;
        logic [LIK_W-1:0] shadow;
        logic [LIK_W-1:0] energy;
    } t_report;

    t_report          expected_reports[$];
    logic [LIK_W-1:0] energy_lik;
    logic [LIK_W-1:0] shadow_lik;
    logic [PWR_W-1:0] adv_ratio;
    logic [PWR_W-1:0] adv_offset;
    logic [PWR_W-1:0] adv_scale;

    function automatic logic [LIK_W-1:0] smooth(input logic [WGT_W-1:0] w_old,
                                                 input logic [LIK_W-1:0] old,
                                                 input logic [WGT_W-1:0] w_new,
                                                 input logic [LIK_W-1:0] nw);
        logic [63:0] acc;
        acc = 64'(w_old) * 64'(old) + 64'(w_new) * 64'(nw);
        return acc[31:16];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        o_fail_count++;
        if (o_fail_count <= 40)
            $display("%0t ns: %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    endtask

    task automatic update_detector(input t_action act, input logic [S_TDATA_W-1:0] d);
        logic [FRM_W-1:0] frames;
        logic             excited;
        logic             active;
        logic [PWR_W-1:0] main_p;
        logic [PWR_W-1:0] shadow_p;
        logic [PWR_W-1:0] far_p;
        logic [PWR_W-1:0] mic_p;
        logic [PWR_W-1:0] erl;
        logic [PWR_W-1:0] excess;
        logic [63:0]      den;
        logic [63:0]      quot;
        logic [63:0]      erl_eff;
        logic [63:0]      echo_bound;
        logic [LIK_W-1:0] raw;
        logic [LIK_W-1:0] inst;
        frames   = d[15:0];
        excited  = d[16];
        main_p   = d[48:17];
        shadow_p = d[80:49];
        active   = d[81];
        far_p    = d[113:82];
        mic_p    = d[145:114];
        erl      = d[177:146];
        unique case (act)
            ACT_SHADOW: begin
                if (frames >= FRAME_GATE && excited) begin
                    // a silent shadow filter counts as one lsb of error
                    den  = (shadow_p == '0) ? 64'd1 : 64'(shadow_p);
                    quot = (64'(main_p) << 24) / den;
                    adv_ratio = (quot > 64'(PWR_ONES)) ? PWR_ONES : quot[31:0];
                    raw = '0;
                    if (adv_ratio > adv_offset) begin
                        if (adv_scale == '0) begin
                            raw = ONE_Q15;
                        end else begin
                            excess = adv_ratio - adv_offset;
                            quot = (64'(excess) << 15) / 64'(adv_scale);
                            raw = (quot > 64'(ONE_Q15)) ? ONE_Q15 : quot[15:0];
                        end
                    end
                    shadow_lik = smooth(W_07, shadow_lik, W_03, raw);
                end else begin
                    shadow_lik = smooth(W_095, shadow_lik, W_0, '0);
                end
            end
            ACT_ENERGY: begin
                inst = '0;
                if (active && far_p > FAR_MIN && mic_p != '0) begin
                    erl_eff    = (erl < ERL_FLOOR) ? 64'(ERL_FLOOR) : 64'(erl);
                    echo_bound = (64'(far_p) << 25) / erl_eff;
                    if (64'(mic_p) > echo_bound) begin
                        quot = ((64'(mic_p) - echo_bound) << 15) / 64'(mic_p);
                        inst = quot[15:0];
                    end
                end
                // fast attack, slow release
                if (inst > energy_lik)
                    energy_lik = smooth(W_03, energy_lik, W_07, inst);
                else
                    energy_lik = smooth(W_09, energy_lik, W_01, inst);
            end
            ACT_CLEAR: begin
                energy_lik = '0;
                shadow_lik = '0;
                adv_ratio  = ONE_Q24;
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (!i_rst_n) begin
            o_fail_count = 0;
            energy_lik = '0;
            shadow_lik = '0;
            adv_ratio  = ONE_Q24;
            adv_offset = ONE_Q24;
            adv_scale  = ONE_Q24;
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_OFFSET: adv_offset = i_cfg_wdata;
                    REG_SCALE:  adv_scale  = i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = t_report'(i_m_tdata);
                if (expected_reports.size() == 0) begin
                    report_mismatch("result with no item pending", got.ratio, '0);
                end else begin
                    want = expected_reports.pop_front();
                    if (got.energy !== want.energy)
                        report_mismatch("energy_likelihood", 32'(got.energy), 32'(want.energy));
                    if (got.shadow !== want.shadow)
                        report_mismatch("shadow_likelihood", 32'(got.shadow), 32'(want.shadow));
                    if (got.ratio !== want.ratio)
                        report_mismatch("advantage_ratio", got.ratio, want.ratio);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                update_detector(t_action'(i_s_tuser), i_s_tdata);
                want.energy = energy_lik;
                want.shadow = shadow_lik;
                want.ratio  = adv_ratio;
                expected_reports.push_back(want);
            end
        end
        o_pending = expected_reports.size();
    end

endmodule

>>> dv/double_talk_detector_core_tb.sv
`timescale 1ns / 1ps
// testbench top for double_talk_detector_core: directed and random frames under several
// threshold settings, bursty sender and stalling receiver; uses dtd_pkg and the checker

module double_talk_detector_core_tb;
    import dtd_pkg::*;

    localparam int ITEMS_PER_PHASE = 68;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [ACT_W-1:0]     s_tuser   = '0;
    logic                 m_tready  = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_AW-1:0]    cfg_addr  = '0;
    logic [PWR_W-1:0]     cfg_wdata = '0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   fail_count;
    int                   pending;
    int                   burst_left = 0;
    logic [31:0]          stall_pattern = '1;
    int                   pattern_age = 0;

    double_talk_detector_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    double_talk_detector_checker dtd_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("double_talk_detector_core verification failed");
        $finish;
    end

    // receiver: rotating ready pattern, reloaded when a random age count runs out
    always @(posedge clk) begin
        if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pattern <= '1;
                1: stall_pattern <= $urandom;
                2: stall_pattern <= ($urandom & $urandom & $urandom) | 32'h1;
                default: stall_pattern <= $urandom | $urandom;
            endcase
            pattern_age <= $urandom_range(60, 500);
        end else begin
            stall_pattern <= {stall_pattern[30:0], stall_pattern[31]};
            pattern_age <= pattern_age - 1;
        end
        m_tready <= stall_pattern[0];
    end

    function automatic logic [S_TDATA_W-1:0] frame_word(
        input logic [FRM_W-1:0] frames, input logic excited,
        input logic [PWR_W-1:0] main_p, input logic [PWR_W-1:0] shadow_p,
        input logic active, input logic [PWR_W-1:0] far_p,
        input logic [PWR_W-1:0] mic_p, input logic [PWR_W-1:0] erl);
        return {6'b0, erl, mic_p, far_p, active, shadow_p, main_p, excited, frames};
    endfunction

    // called at a rising edge; returns after the item is taken and any burst-end gap
    task automatic send_item(input t_action act, input logic [S_TDATA_W-1:0] data);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= act;
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 100)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(0, 8);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [PWR_W-1:0] offset,
                                  input logic [PWR_W-1:0] scale);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_OFFSET;
        cfg_wdata <= offset;
        @(posedge clk);
        cfg_addr  <= REG_SCALE;
        cfg_wdata <= scale;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // well-formed frame of the given kind: powers chosen so ratios and echo bounds
    // land near the thresholds rather than always saturating
    task automatic random_item(input t_action kind, output logic [S_TDATA_W-1:0] data);
        logic [FRM_W-1:0] frames;
        logic             excited;
        logic             active;
        logic [PWR_W-1:0] main_p;
        logic [PWR_W-1:0] shadow_p;
        logic [PWR_W-1:0] far_p;
        logic [PWR_W-1:0] mic_p;
        logic [PWR_W-1:0] erl;
        logic [63:0]      scaled;
        logic [63:0]      bound;
        frames   = FRM_W'($urandom);
        excited  = 1'($urandom);
        active   = 1'($urandom);
        main_p   = $urandom;
        shadow_p = $urandom;
        far_p    = $urandom;
        mic_p    = $urandom;
        erl      = $urandom;
        if (kind == ACT_SHADOW) begin
            frames   = ($urandom_range(0, 9) == 0) ? FRM_W'($urandom_range(0, 49))
                                                   : FRM_W'($urandom_range(50, 65535));
            excited  = ($urandom_range(0, 9) != 0);
            shadow_p = $urandom >> $urandom_range(0, 28);
            scaled   = (64'(shadow_p) * $urandom_range(0, 160)) >> 5;
            main_p   = (scaled > 64'(PWR_ONES)) ? PWR_ONES : scaled[31:0];
        end else if (kind == ACT_ENERGY) begin
            active = ($urandom_range(0, 9) != 0);
            far_p  = $urandom >> $urandom_range(2, 30);
            erl    = $urandom >> $urandom_range(0, 14);
            bound  = (64'(far_p) << 25) / ((erl < ERL_FLOOR) ? 64'(ERL_FLOOR) : 64'(erl));
            scaled = (bound * $urandom_range(0, 64)) >> 4;
            mic_p  = (scaled == 0 || scaled > 64'(PWR_ONES)) ? $urandom : scaled[31:0];
        end
        data = frame_word(frames, excited, main_p, shadow_p, active, far_p, mic_p, erl);
    endtask

    task automatic random_phase(input int count);
        int                   n;
        int                   pick;
        int                   run;
        t_action              kind;
        logic [191:0]         noise;
        logic [S_TDATA_W-1:0] data;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(0, 99);
            kind = (pick < 45) ? ACT_SHADOW : (pick < 88) ? ACT_ENERGY :
                   (pick < 94) ? ACT_CLEAR : ACT_NONE;
            run  = (kind == ACT_SHADOW || kind == ACT_ENERGY) ? $urandom_range(1, 12) : 1;
            repeat (run) begin
                if ($urandom_range(0, 7) == 0) begin
                    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
                    data  = noise[S_TDATA_W-1:0];
                    data[S_TDATA_W-1:178] = '0;
                    send_item(t_action'(2'($urandom_range(0, 3))), data);
                end else begin
                    random_item(kind, data);
                    send_item(kind, data);
                end
                n++;
                if ($urandom_range(0, 49) == 0)
                    drain();
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames at the reset thresholds (offset 1.0, scale 1.0)
        send_item(ACT_CLEAR, frame_word('0, 1'b0, '0, '0, 1'b0, '0, '0, '0));
        send_item(ACT_SHADOW, frame_word(16'd49, 1'b1, 32'h0200_0000, ONE_Q24,
                                         1'b0, '0, '0, '0));
        send_item(ACT_SHADOW, frame_word(FRAME_GATE, 1'b0, 32'h0200_0000, ONE_Q24,
                                         1'b0, '0, '0, '0));
        send_item(ACT_SHADOW, frame_word(FRAME_GATE, 1'b1, 32'h0200_0000, ONE_Q24,
                                         1'b0, '0, '0, '0));
        // silent shadow filter, ratio saturates
        send_item(ACT_SHADOW, frame_word(16'hFFFF, 1'b1, PWR_ONES, '0,
                                         1'b1, PWR_ONES, PWR_ONES, PWR_ONES));
        send_item(ACT_SHADOW, frame_word(FRAME_GATE, 1'b1, '0, PWR_ONES,
                                         1'b0, '0, '0, '0));
        send_item(ACT_SHADOW, frame_word(FRAME_GATE, 1'b1, 32'h0180_0000, ONE_Q24,
                                         1'b0, '0, '0, '0));
        // ratio exactly at the offset
        send_item(ACT_SHADOW, frame_word(FRAME_GATE, 1'b1, 32'h0300_0000, 32'h0300_0000,
                                         1'b0, '0, '0, '0));
        send_item(ACT_ENERGY, frame_word('0, 1'b0, '0, '0, 1'b1, FAR_MIN, PWR_ONES, ONE_Q24));
        send_item(ACT_ENERGY, frame_word('0, 1'b0, '0, '0, 1'b1, FAR_MIN + 32'd1,
                                         PWR_ONES, '0));
        // silent mic
        send_item(ACT_ENERGY, frame_word('0, 1'b0, '0, '0, 1'b1, ONE_Q24, '0, ONE_Q24));
        send_item(ACT_ENERGY, frame_word('0, 1'b0, '0, '0, 1'b0, ONE_Q24, PWR_ONES, ONE_Q24));
        send_item(ACT_ENERGY, frame_word('0, 1'b0, '0, '0, 1'b1, PWR_ONES, PWR_ONES, PWR_ONES));
        send_item(ACT_ENERGY, frame_word('0, 1'b0, '0, '0, 1'b1, ONE_Q24, 32'h0300_0000,
                                         ERL_FLOOR - 32'd1));
        send_item(ACT_ENERGY, frame_word('0, 1'b0, '0, '0, 1'b1, ONE_Q24, 32'h0400_0000,
                                         ONE_Q24));
        send_item(ACT_NONE, frame_word(16'hFFFF, 1'b1, PWR_ONES, PWR_ONES,
                                       1'b1, PWR_ONES, PWR_ONES, PWR_ONES));
        send_item(ACT_CLEAR, frame_word(16'hFFFF, 1'b1, PWR_ONES, PWR_ONES,
                                        1'b1, PWR_ONES, PWR_ONES, PWR_ONES));
        send_item(ACT_ENERGY, frame_word('0, 1'b0, '0, '0, 1'b1, PWR_ONES, PWR_ONES, PWR_ONES));
        send_item(ACT_NONE, frame_word('0, 1'b0, '0, '0, 1'b0, '0, '0, '0));
        random_phase(ITEMS_PER_PHASE);

        set_thresholds(32'h0, 32'h1);
        random_phase(ITEMS_PER_PHASE);
        set_thresholds(PWR_ONES, PWR_ONES);
        random_phase(ITEMS_PER_PHASE);
        set_thresholds(32'h0080_0000, 32'h0200_0000);
        random_phase(ITEMS_PER_PHASE);
        // zero scale turns any excess into full likelihood
        set_thresholds(ONE_Q24, 32'h0);
        random_phase(ITEMS_PER_PHASE);
        set_thresholds($urandom_range(0, 32'h0300_0000), $urandom_range(32'h0020_0000,
                                                                        32'h0400_0000));
        random_phase(ITEMS_PER_PHASE);
        set_thresholds(32'h00C0_0000, 32'h0019_9999);
        random_phase(ITEMS_PER_PHASE);
        set_thresholds(ONE_Q24, ONE_Q24);
        random_phase(ITEMS_PER_PHASE);

        drain();
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("double_talk_detector_core verification clean");
        else
            $display("double_talk_detector_core verification failed");
        $finish;
    end

endmodule
